FILE: rtl/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared constants, types and tables for the Cartesian to spherical core.
// ----------------------------------------------------------------------------
package c2s_pkg;

  // field widths
  localparam int COORD_W   = 32;
  localparam int RAD_W     = 32;
  localparam int ANG_OUT_W = 18;
  localparam int STAT_W    = 2;

  // default CORDIC depth
  localparam int CORDIC_STAGES_DEF = 20;

  // integer square root: one result bit per stage plus a rounding stage
  localparam int SQRT_IN_W  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int SQRT_LAT   = SQRT_STEPS + 1;

  // CORDIC datapath width (vector growth and Q2.30 angle sums fit)
  localparam int CW = 36;

  localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CW-1:0] ROUND_HALF  = 36'sd8192;
  localparam logic signed [CW-1:0] POLAR_MAX   = 36'sd205887;
  localparam logic signed [CW-1:0] AZIM_MAX    = 36'sd102944;
  localparam int                   Q16_SHIFT   = 14;

  typedef enum logic [STAT_W-1:0] {
    ST_NORMAL = 2'd0,
    ST_X_ZERO = 2'd1,
    ST_ORIGIN = 2'd2
  } status_t;

  // atan(2^-i) in Q2.30
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  // special-case flags that ride along with a point
  typedef struct packed {
    logic origin;
    logic x_zero;
    logic y_pos;
    logic y_neg;
  } c2s_flag_t;

  // CORDIC start vectors and flags, carried past the square roots
  typedef struct packed {
    logic signed [CW-1:0] az_x;
    logic signed [CW-1:0] az_y;
    logic signed [CW-1:0] pol_y;
    c2s_flag_t            flg;
  } c2s_side_t;

endpackage

FILE: rtl/c2s_isqrt.sv
// ----------------------------------------------------------------------------
// c2s_isqrt
// Pipelined 64-bit integer square root, rounded to nearest. One result bit
// per stage, then a rounding stage.
// ----------------------------------------------------------------------------
module c2s_isqrt (
  input  logic                            clk,
  input  logic                            en,
  input  logic [c2s_pkg::SQRT_IN_W-1:0]   rad_in,
  output logic [c2s_pkg::RAD_W-1:0]       root_out
);
  import c2s_pkg::*;

  logic [SQRT_IN_W-1:0] rem_r [SQRT_STEPS];
  logic [SQRT_IN_W-1:0] res_r [SQRT_STEPS];
  logic [RAD_W-1:0]     root_r;

  // restoring square root, one bit pair per stage
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [SQRT_IN_W-1:0] BIT = SQRT_IN_W'(1) << (62 - 2 * i);
    logic [SQRT_IN_W-1:0] rem_in, res_in, trial, rem_nxt, res_nxt;

    if (i == 0) begin : g_head
      assign rem_in = rad_in;
      assign res_in = '0;
    end else begin : g_body
      assign rem_in = rem_r[i-1];
      assign res_in = res_r[i-1];
    end

    always_comb begin
      trial = res_in + BIT;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        res_r[i] <= res_nxt;
      end
    end
  end

  // round up when the remainder exceeds the floor root
  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= res_r[SQRT_STEPS-1][RAD_W-1:0]
              + RAD_W'(rem_r[SQRT_STEPS-1] > res_r[SQRT_STEPS-1]);
    end
  end

  assign root_out = root_r;

endmodule

FILE: rtl/cartesian_to_spherical_core.sv
// Throughput: one point per cycle; the whole pipeline advances together and
// holds as a unit while a result beat waits on out_ready.
// The depth comes from the input stages, the two 33-stage square roots, the CORDIC stages and the output stage.
// Reset: synchronous, active low; clears only the stage valid bits.
// ----------------------------------------------------------------------------
// cartesian_to_spherical_core
// Converts a Q15.16 point to radius, polar angle and azimuth through a deep
// pipeline of square roots and two CORDIC vectoring chains.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_core #(
  parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [c2s_pkg::COORD_W-1:0]      in_x_coord,
  input  logic signed [c2s_pkg::COORD_W-1:0]      in_y_coord,
  input  logic signed [c2s_pkg::COORD_W-1:0]      in_z_coord,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [c2s_pkg::RAD_W-1:0]               out_radius,
  output logic [c2s_pkg::ANG_OUT_W-1:0]           out_polar_angle,
  output logic signed [c2s_pkg::ANG_OUT_W-1:0]    out_azimuth,
  output logic [c2s_pkg::STAT_W-1:0]              out_status
);
  import c2s_pkg::*;

  localparam int PRE_STAGES = 6;
  localparam int DEPTH      = PRE_STAGES + SQRT_LAT + CORDIC_STAGES + 1;

  logic             en;
  logic [DEPTH-1:0] vld_r;

  // whole pipeline moves unless the result beat is stuck
  assign en       = !vld_r[DEPTH-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  // stage 1: magnitudes and signs
  logic [COORD_W-1:0] ax_nxt, ay_nxt, az_nxt;
  logic [COORD_W-1:0] s1_ax_r, s1_ay_r, s1_az_r;
  logic               s1_xn_r, s1_yn_r, s1_zn_r;

  assign ax_nxt = in_x_coord[COORD_W-1] ? (~$unsigned(in_x_coord) + 32'd1)
                                        : $unsigned(in_x_coord);
  assign ay_nxt = in_y_coord[COORD_W-1] ? (~$unsigned(in_y_coord) + 32'd1)
                                        : $unsigned(in_y_coord);
  assign az_nxt = in_z_coord[COORD_W-1] ? (~$unsigned(in_z_coord) + 32'd1)
                                        : $unsigned(in_z_coord);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax_r <= ax_nxt;
      s1_ay_r <= ay_nxt;
      s1_az_r <= az_nxt;
      s1_xn_r <= in_x_coord[COORD_W-1];
      s1_yn_r <= in_y_coord[COORD_W-1];
      s1_zn_r <= in_z_coord[COORD_W-1];
    end
  end

  // stage 2: squares and largest magnitude
  logic [COORD_W-1:0]   m_nxt, s2_m_r;
  logic [SQRT_IN_W-1:0] s2_sqx_r, s2_sqy_r, s2_sqz_r;
  logic [COORD_W-1:0]   s2_ax_r, s2_ay_r, s2_az_r;
  logic                 s2_xn_r, s2_yn_r, s2_zn_r;

  always_comb begin
    m_nxt = s1_ax_r;
    if (s1_ay_r > m_nxt) m_nxt = s1_ay_r;
    if (s1_az_r > m_nxt) m_nxt = s1_az_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sqx_r <= SQRT_IN_W'(s1_ax_r) * SQRT_IN_W'(s1_ax_r);
      s2_sqy_r <= SQRT_IN_W'(s1_ay_r) * SQRT_IN_W'(s1_ay_r);
      s2_sqz_r <= SQRT_IN_W'(s1_az_r) * SQRT_IN_W'(s1_az_r);
      s2_m_r   <= m_nxt;
      s2_ax_r  <= s1_ax_r;
      s2_ay_r  <= s1_ay_r;
      s2_az_r  <= s1_az_r;
      s2_xn_r  <= s1_xn_r;
      s2_yn_r  <= s1_yn_r;
      s2_zn_r  <= s1_zn_r;
    end
  end

  // stage 3: radius sum and normalize shift count
  logic [4:0]           msb, k_nxt, s3_k_r;
  logic [SQRT_IN_W-1:0] s3_sum_r;
  logic                 s3_org_r;
  logic [COORD_W-1:0]   s3_ax_r, s3_ay_r, s3_az_r;
  logic                 s3_xn_r, s3_yn_r, s3_zn_r;

  always_comb begin
    msb = '0;
    for (int j = 0; j < COORD_W; j++) begin
      if (s2_m_r[j]) msb = 5'(j);
    end
    if (s2_m_r[31] || s2_m_r[30]) k_nxt = '0;
    else                          k_nxt = 5'd30 - msb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum_r <= s2_sqx_r + s2_sqy_r + s2_sqz_r;
      s3_k_r   <= k_nxt;
      s3_org_r <= (s2_m_r == '0);
      s3_ax_r  <= s2_ax_r;
      s3_ay_r  <= s2_ay_r;
      s3_az_r  <= s2_az_r;
      s3_xn_r  <= s2_xn_r;
      s3_yn_r  <= s2_yn_r;
      s3_zn_r  <= s2_zn_r;
    end
  end

  // stage 4: scaled magnitudes, special-case flags
  logic [COORD_W-1:0]   s4_xm_r, s4_ym_r, s4_zm_r;
  logic [SQRT_IN_W-1:0] s4_sum_r;
  logic                 s4_xn_r, s4_yn_r, s4_zn_r;
  c2s_flag_t            s4_flg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_xm_r         <= s3_ax_r << s3_k_r;
      s4_ym_r         <= s3_ay_r << s3_k_r;
      s4_zm_r         <= s3_az_r << s3_k_r;
      s4_sum_r        <= s3_sum_r;
      s4_xn_r         <= s3_xn_r;
      s4_yn_r         <= s3_yn_r;
      s4_zn_r         <= s3_zn_r;
      s4_flg_r.origin <= s3_org_r;
      s4_flg_r.x_zero <= (s3_ax_r == '0);
      s4_flg_r.y_pos  <= !s3_yn_r && (s3_ay_r != '0);
      s4_flg_r.y_neg  <= s3_yn_r;
    end
  end

  // stage 5: rho squares, CORDIC start vectors (azimuth folded to x >= 0)
  logic signed [CW-1:0] xm_s, ym_s, zm_s;
  c2s_side_t            side_nxt, s5_side_r;
  logic [SQRT_IN_W-1:0] s5_sqx_r, s5_sqy_r, s5_sum_r;

  assign xm_s = $signed({4'b0, s4_xm_r});
  assign ym_s = $signed({4'b0, s4_ym_r});
  assign zm_s = $signed({4'b0, s4_zm_r});

  always_comb begin
    side_nxt.az_x  = xm_s;
    side_nxt.az_y  = (s4_yn_r ^ s4_xn_r) ? -ym_s : ym_s;
    side_nxt.pol_y = s4_zn_r ? zm_s : -zm_s;
    side_nxt.flg   = s4_flg_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sqx_r  <= SQRT_IN_W'(s4_xm_r) * SQRT_IN_W'(s4_xm_r);
      s5_sqy_r  <= SQRT_IN_W'(s4_ym_r) * SQRT_IN_W'(s4_ym_r);
      s5_sum_r  <= s4_sum_r;
      s5_side_r <= side_nxt;
    end
  end

  // stage 6: rho sum
  logic [SQRT_IN_W-1:0] s6_sum1_r, s6_sum2_r;
  c2s_side_t            s6_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_sum1_r <= s5_sum_r;
      s6_sum2_r <= s5_sqx_r + s5_sqy_r;
      s6_side_r <= s5_side_r;
    end
  end

  // square roots for radius and rho
  logic [RAD_W-1:0] radius_root, rho_root;

  c2s_isqrt u_rad_sqrt (
    .clk      (clk),
    .en       (en),
    .rad_in   (s6_sum1_r),
    .root_out (radius_root)
  );

  c2s_isqrt u_rho_sqrt (
    .clk      (clk),
    .en       (en),
    .rad_in   (s6_sum2_r),
    .root_out (rho_root)
  );

  // side data delayed to match the square roots
  c2s_side_t sb_r [SQRT_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= s6_side_r;
      for (int j = 1; j < SQRT_LAT; j++) begin
        sb_r[j] <= sb_r[j-1];
      end
    end
  end

  // CORDIC vectoring chains: polar (rho, -z) and azimuth (x, y)
  logic signed [CW-1:0] pol_x [CORDIC_STAGES+1];
  logic signed [CW-1:0] pol_y [CORDIC_STAGES+1];
  logic signed [CW-1:0] pol_a [CORDIC_STAGES+1];
  logic signed [CW-1:0] az_x  [CORDIC_STAGES+1];
  logic signed [CW-1:0] az_y  [CORDIC_STAGES+1];
  logic signed [CW-1:0] az_a  [CORDIC_STAGES+1];
  logic [RAD_W-1:0]     rad_d [CORDIC_STAGES+1];
  c2s_flag_t            flg_d [CORDIC_STAGES+1];

  logic signed [CW-1:0] pol_x_r [CORDIC_STAGES];
  logic signed [CW-1:0] pol_y_r [CORDIC_STAGES];
  logic signed [CW-1:0] pol_a_r [CORDIC_STAGES];
  logic signed [CW-1:0] az_x_r  [CORDIC_STAGES];
  logic signed [CW-1:0] az_y_r  [CORDIC_STAGES];
  logic signed [CW-1:0] az_a_r  [CORDIC_STAGES];
  logic [RAD_W-1:0]     rad_r   [CORDIC_STAGES];
  c2s_flag_t            flg_r   [CORDIC_STAGES];

  assign pol_x[0] = $signed({4'b0, rho_root});
  assign pol_y[0] = sb_r[SQRT_LAT-1].pol_y;
  assign pol_a[0] = '0;
  assign az_x[0]  = sb_r[SQRT_LAT-1].az_x;
  assign az_y[0]  = sb_r[SQRT_LAT-1].az_y;
  assign az_a[0]  = '0;
  assign rad_d[0] = radius_root;
  assign flg_d[0] = sb_r[SQRT_LAT-1].flg;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [CW-1:0] p_dx, p_dy, a_dx, a_dy, atan_i;

    assign atan_i = $signed({4'b0, ATAN_Q30[i]});
    assign p_dx   = pol_y[i] >>> i;
    assign p_dy   = pol_x[i] >>> i;
    assign a_dx   = az_y[i] >>> i;
    assign a_dy   = az_x[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!pol_y[i][CW-1]) begin
          pol_x_r[i] <= pol_x[i] + p_dx;
          pol_y_r[i] <= pol_y[i] - p_dy;
          pol_a_r[i] <= pol_a[i] + atan_i;
        end else begin
          pol_x_r[i] <= pol_x[i] - p_dx;
          pol_y_r[i] <= pol_y[i] + p_dy;
          pol_a_r[i] <= pol_a[i] - atan_i;
        end
        if (!az_y[i][CW-1]) begin
          az_x_r[i] <= az_x[i] + a_dx;
          az_y_r[i] <= az_y[i] - a_dy;
          az_a_r[i] <= az_a[i] + atan_i;
        end else begin
          az_x_r[i] <= az_x[i] - a_dx;
          az_y_r[i] <= az_y[i] + a_dy;
          az_a_r[i] <= az_a[i] - atan_i;
        end
        rad_r[i] <= rad_d[i];
        flg_r[i] <= flg_d[i];
      end
    end

    assign pol_x[i+1] = pol_x_r[i];
    assign pol_y[i+1] = pol_y_r[i];
    assign pol_a[i+1] = pol_a_r[i];
    assign az_x[i+1]  = az_x_r[i];
    assign az_y[i+1]  = az_y_r[i];
    assign az_a[i+1]  = az_a_r[i];
    assign rad_d[i+1] = rad_r[i];
    assign flg_d[i+1] = flg_r[i];
  end

  // output stage: Q2.30 to Q.16, clamp, special cases
  logic signed [CW-1:0]        pol_q, az_q, pol_c, az_c;
  logic [ANG_OUT_W-1:0]        polar_nxt;
  logic signed [ANG_OUT_W-1:0] azim_nxt;
  status_t                     status_nxt;
  c2s_flag_t                   flg_o;

  assign flg_o = flg_d[CORDIC_STAGES];

  always_comb begin
    pol_q = (pol_a[CORDIC_STAGES] + HALF_PI_Q30 + ROUND_HALF) >>> Q16_SHIFT;
    az_q  = (az_a[CORDIC_STAGES] + ROUND_HALF) >>> Q16_SHIFT;

    if (pol_q < 0)              pol_c = '0;
    else if (pol_q > POLAR_MAX) pol_c = POLAR_MAX;
    else                        pol_c = pol_q;

    if (az_q > AZIM_MAX)       az_c = AZIM_MAX;
    else if (az_q < -AZIM_MAX) az_c = -AZIM_MAX;
    else                       az_c = az_q;

    priority if (flg_o.origin) begin
      polar_nxt  = '0;
      azim_nxt   = '0;
      status_nxt = ST_ORIGIN;
    end else if (flg_o.x_zero) begin
      polar_nxt  = pol_c[ANG_OUT_W-1:0];
      status_nxt = ST_X_ZERO;
      if (flg_o.y_pos)      azim_nxt = AZIM_MAX[ANG_OUT_W-1:0];
      else if (flg_o.y_neg) azim_nxt = -AZIM_MAX[ANG_OUT_W-1:0];
      else                  azim_nxt = '0;
    end else begin
      polar_nxt  = pol_c[ANG_OUT_W-1:0];
      azim_nxt   = az_c[ANG_OUT_W-1:0];
      status_nxt = ST_NORMAL;
    end
  end

  logic [RAD_W-1:0]            out_radius_r;
  logic [ANG_OUT_W-1:0]        out_polar_r;
  logic signed [ANG_OUT_W-1:0] out_azim_r;
  status_t                     out_status_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_radius_r <= rad_d[CORDIC_STAGES];
      out_polar_r  <= polar_nxt;
      out_azim_r   <= azim_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_valid       = vld_r[DEPTH-1];
  assign out_radius      = out_radius_r;
  assign out_polar_angle = out_polar_r;
  assign out_azimuth     = out_azim_r;
  assign out_status      = out_status_r;

endmodule

FILE: rtl/c2s_checker.sv
// ----------------------------------------------------------------------------
// c2s_checker
// Port-level checks for the Cartesian to spherical core, bound to the top.
// ----------------------------------------------------------------------------
module c2s_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [c2s_pkg::RAD_W-1:0]            out_radius,
  input logic [c2s_pkg::ANG_OUT_W-1:0]        out_polar_angle,
  input logic signed [c2s_pkg::ANG_OUT_W-1:0] out_azimuth,
  input logic [c2s_pkg::STAT_W-1:0]           out_status
);
  import c2s_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_radius)
      && $stable(out_polar_angle) && $stable(out_azimuth))
    else $error("result beat changed while stalled");

  // the core takes a beat whenever the result slot is free
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result slot");

  // origin gives zero radius and angles
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ORIGIN |-> out_radius == '0
      && out_polar_angle == '0 && out_azimuth == '0)
    else $error("origin beat with nonzero fields");

  // x zero forces the azimuth to a quarter turn or zero
  a_x_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_X_ZERO |->
      out_azimuth == 18'sd102944 || out_azimuth == -18'sd102944 || out_azimuth == '0)
    else $error("x-zero beat with free azimuth");

  // angles stay in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_polar_angle <= 18'd205887
      && out_azimuth <= 18'sd102944 && out_azimuth >= -18'sd102944
      && out_status != 2'd3)
    else $error("angle out of range");

endmodule

bind cartesian_to_spherical_core c2s_checker u_c2s_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream test of cartesian_to_spherical_core: directed corner points, then
// random points under several idle/stall mixes, checked against a local
// bit-exact square-root and CORDIC predictor.
// ----------------------------------------------------------------------------
module tb;
  import c2s_pkg::*;

  localparam int  NSTAGE    = CORDIC_STAGES_DEF;
  localparam int  LATENCY   = 40 + NSTAGE;
  localparam int  CYCLE_MAX = 400000;

  typedef struct {
    logic [RAD_W-1:0]            radius;
    logic [ANG_OUT_W-1:0]        polar;
    logic signed [ANG_OUT_W-1:0] azim;
    status_t                     status;
  } sph_point_t;

  // predicts each converted point and checks results in order
  class sph_scoreboard;
    sph_point_t pending_q[$];
    int         errors = 0;
    longint     atan_tab[32] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0
    };

    function longint unsigned root_near(longint unsigned v);
      longint unsigned res, b, s;
      res = 0;
      b = 64'd1 << 62;
      s = v;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= res + b) begin
          s = s - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      if (v - res * res > res) res = res + 1;
      return res;
    endfunction

    // vectoring CORDIC, angle in Q2.30, px >= 0
    function longint cordic_angle(longint px, longint py);
      longint ang, dx, dy;
      ang = 0;
      for (int i = 0; i < NSTAGE && i < 32; i++) begin
        dx = py >>> i;
        dy = px >>> i;
        if (py >= 0) begin
          px = px + dx;
          py = py - dy;
          ang = ang + atan_tab[i];
        end else begin
          px = px - dx;
          py = py + dy;
          ang = ang - atan_tab[i];
        end
      end
      return ang;
    endfunction

    function longint to_q16(longint a);
      return (a + 8192) >>> 14;
    endfunction

    function void note(logic signed [31:0] xi, logic signed [31:0] yi,
                       logic signed [31:0] zi);
      longint          x, y, z, xs, ys, zs, pol, az;
      longint unsigned ax, ay, az_m, m, rho;
      int              k;
      sph_point_t      e;
      x = xi; y = yi; z = zi;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az_m = (z < 0) ? -z : z;
      e.radius = root_near(ax * ax + ay * ay + az_m * az_m);
      m = ax;
      if (ay > m) m = ay;
      if (az_m > m) m = az_m;
      if (m == 0) begin
        e.polar = 0; e.azim = 0; e.status = ST_ORIGIN;
        pending_q.push_back(e);
        return;
      end
      // normalize so the largest magnitude reaches 2^30
      k = 0;
      while (m < (64'd1 << 30)) begin
        m = m << 1;
        k++;
      end
      xs = x <<< k; ys = y <<< k; zs = z <<< k;
      rho = root_near(xs * xs + ys * ys);
      pol = to_q16(1686629713 + cordic_angle(rho, -zs));
      if (pol < 0) pol = 0;
      if (pol > 205887) pol = 205887;
      if (x == 0) begin
        e.status = ST_X_ZERO;
        az = (y > 0) ? 102944 : ((y < 0) ? -102944 : 0);
      end else begin
        e.status = ST_NORMAL;
        if (xs < 0) begin
          xs = -xs;
          ys = -ys;
        end
        az = to_q16(cordic_angle(xs, ys));
        if (az > 102944) az = 102944;
        if (az < -102944) az = -102944;
      end
      e.polar = pol[ANG_OUT_W-1:0];
      e.azim  = az[ANG_OUT_W-1:0];
      pending_q.push_back(e);
    endfunction

    function void check(logic [RAD_W-1:0] r, logic [ANG_OUT_W-1:0] p,
                        logic [ANG_OUT_W-1:0] a, logic [STAT_W-1:0] s);
      sph_point_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat radius %h", $time, r);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (r !== e.radius) begin
        $display("%0t: radius exp %h got %h", $time, e.radius, r);
        errors++;
      end
      if (p !== e.polar) begin
        $display("%0t: polar_angle exp %h got %h", $time, e.polar, p);
        errors++;
      end
      if (a !== e.azim) begin
        $display("%0t: azimuth exp %h got %h", $time, e.azim, a);
        errors++;
      end
      if (s !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, s);
        errors++;
      end
    endfunction
  endclass

  logic                        clk = 0;
  logic                        rst_n = 0;
  logic                        in_valid = 0;
  logic                        in_ready;
  logic signed [COORD_W-1:0]   in_x_coord = '0, in_y_coord = '0, in_z_coord = '0;
  logic                        out_valid;
  logic                        out_ready = 0;
  logic [RAD_W-1:0]            out_radius;
  logic [ANG_OUT_W-1:0]        out_polar_angle;
  logic signed [ANG_OUT_W-1:0] out_azimuth;
  logic [STAT_W-1:0]           out_status;

  sph_scoreboard sb = new();
  int            send_idle_pct = 0;
  int            stall_pct = 0;
  int            hold_left = 0;
  int            cycles = 0;

  cartesian_to_spherical_core DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // beat monitor and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_n) begin
      if (in_valid && in_ready) sb.note(in_x_coord, in_y_coord, in_z_coord);
      if (out_valid && out_ready)
        sb.check(out_radius, out_polar_angle, out_azimuth, out_status);
    end
  end

  // result side: random stall or a long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    in_z_coord <= z;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2, 3:    return $urandom_range(1) ? $urandom_range(65536)
                                        : -$urandom_range(65536);
      4:       return $urandom_range(1) ? $urandom_range(255) : -$urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  // the caller drops in_valid once the last phase is done
  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: origin, x zero cases, axes, extremes, negative x
    send_point(32'd0, 32'd0, 32'd0);
    send_point(32'd0, 32'd65536, 32'd0);
    send_point(32'd0, -32'sd65536, 32'd0);
    send_point(32'd0, 32'd0, 32'd65536);
    send_point(32'd0, 32'd0, -32'sd65536);
    send_point(32'd0, 32'd5, 32'd7);
    send_point(32'd1, 32'd0, 32'd0);
    send_point(32'hffffffff, 32'd0, 32'd0);
    send_point(32'd0, 32'd0, 32'd1);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000);
    send_point(32'h7fffffff, 32'h80000000, 32'd0);
    send_point(-32'sd65536, 32'd65536, 32'd0);
    send_point(-32'sd65536, -32'sd65536, 32'd65536);
    send_point(32'd65536, 32'd65536, 32'd65536);
    send_point(32'd1, 32'd1, 32'd1);
    send_point(32'hffffffff, 32'h7fffffff, 32'd0);
    send_point(32'd0, 32'h80000000, 32'h7fffffff);
    send_point(32'd3, 32'hfffffffd, 32'h80000000);
    in_valid <= 1'b0;
    drain();

    // random phases: free flow, sender idle, receiver stall, both
    send_idle_pct = 0;  stall_pct = 0;  send_random(200);
    send_idle_pct = 71; stall_pct = 0;  send_random(180);
    send_idle_pct = 0;  stall_pct = 71; send_random(180);
    send_idle_pct = 27; stall_pct = 27; send_random(180);

    // receiver holds off long enough for the pipeline to back up
    send_idle_pct = 0;  stall_pct = 10;
    hold_left = 4 * LATENCY;
    send_random(160);
    in_valid <= 1'b0;

    drain();
    repeat (2 * LATENCY) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/c2s_pkg.sv
rtl/c2s_isqrt.sv
rtl/cartesian_to_spherical_core.sv
rtl/c2s_checker.sv
tb/sv/tb.sv
